@@ rtl/core/thi_pkg.sv @@
// Shared types and constants for the thermistor table interpolator.
// Used by the top level and the serial divider; no dependencies.

package thi_pkg;

   // field widths of the stream items
   localparam int KIND_W  = 2;
   localparam int INDEX_W = 6;
   localparam int ADC_W   = 10;
   localparam int CEL_W   = 16;
   localparam int Q8_W    = 24;
   localparam int ENT_W   = 7;

   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 32;

   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 10;

   // interpolation datapath
   localparam int MUL_W = CEL_W + ADC_W + 2;   // 17 x 11 signed product
   localparam int NUM_W = MUL_W + 1;           // sum of two products
   localparam int DVD_W = NUM_W + 8;           // numerator magnitude times 256

   localparam int MIN_ENTRIES = 3;
   localparam int Q8_POS_MAG  = 8388607;
   localparam int Q8_NEG_MAG  = 8388608;
   localparam logic [Q8_W-1:0] Q8_MAX = 24'h7FFFFF;
   localparam logic [Q8_W-1:0] Q8_MIN = 24'h800000;

   localparam logic [ADC_W-1:0] FAULT_LOW_RST  = 10'd5;
   localparam logic [ADC_W-1:0] FAULT_HIGH_RST = 10'd1018;
   localparam logic [ENT_W-1:0] ENTRIES_RST    = 7'd64;

   typedef enum logic [KIND_W-1:0] {
      KIND_WRITE   = 2'd0,
      KIND_CONVERT = 2'd1,
      KIND_CLEAR   = 2'd2
   } kind_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_FAULT_LOW  = 2'd0,
      REG_FAULT_HIGH = 2'd1,
      REG_ENTRIES    = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic             start;
      logic [DVD_W-1:0] dividend;
      logic [ADC_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DVD_W-1:0] quotient;
   } div_rsp_type;

endpackage

@@ rtl/core/thermistor_table_interpolator.sv @@
// Thermistor ADC to Q8 Celsius converter: table RAM, linear walk, serial divide.
// Depends on thi_pkg, thi_ram and thi_div.
//
// Load the table first with write beats (kind 0), in ascending adc order; a
// conversion beat (kind 1) then walks the table from entry 0 through the single
// RAM read port, one entry per cycle, until it finds the first entry above the
// sample, and interpolates on the segment ending there with one shared 17x11
// multiplier and a bit-serial divider; if none is found by the last searched
// entry, the celsius of the entry after it is returned. A conversion ends sooner
// when the segment is found early or has zero width; write, clear and unused
// beats go straight to ST_OUT. Every beat gives one result beat; the next
// request is taken while an earlier result still waits in the output register.
// Table entries are not cleared by reset and must be written before they are
// used; configuration writes are taken at any time but should only be made
// while no conversion is in flight.

module thermistor_table_interpolator #(
   parameter int TABLE_ENTRIES = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // entry_index[5:0], entry_adc[15:6], entry_celsius[31:16], raw_sample[41:32]
   input  logic [thi_pkg::REQ_DATA_W-1:0]    req_tdata,
   // kind[1:0]
   input  logic [thi_pkg::KIND_W-1:0]        req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // celsius_q8[23:0], sample_bad[24], fault_sticky[25]
   output logic [thi_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                              csr_we,
   input  logic [thi_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [thi_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import thi_pkg::*;

   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam int N_W   = ($clog2(TABLE_ENTRIES + 1) > ENT_W) ?
                          $clog2(TABLE_ENTRIES + 1) : ENT_W;
   localparam int RAM_W = ADC_W + CEL_W;

   typedef enum logic [8:0] {
      ST_IDLE = 9'b000000001,
      ST_SCAN = 9'b000000010,
      ST_LAST = 9'b000000100,
      ST_DIFF = 9'b000001000,
      ST_MUL0 = 9'b000010000,
      ST_MUL1 = 9'b000100000,
      ST_DIVS = 9'b001000000,
      ST_DIVW = 9'b010000000,
      ST_OUT  = 9'b100000000
   } state_type;

   // request fields
   logic [INDEX_W-1:0] req_index;
   logic [ADC_W-1:0]   req_adc;
   logic [CEL_W-1:0]   req_cel;
   logic [ADC_W-1:0]   req_sample;

   assign req_index  = req_tdata[5:0];
   assign req_adc    = req_tdata[15:6];
   assign req_cel    = req_tdata[31:16];
   assign req_sample = req_tdata[41:32];

   // configuration
   logic [ADC_W-1:0] fault_low_ff, fault_high_ff;
   logic [ENT_W-1:0] entries_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fault_low_ff  <= FAULT_LOW_RST;
         fault_high_ff <= FAULT_HIGH_RST;
         entries_ff    <= ENTRIES_RST;
      end else if (csr_we) begin
         case (csr_addr)
            REG_FAULT_LOW:  fault_low_ff  <= csr_wdata[ADC_W-1:0];
            REG_FAULT_HIGH: fault_high_ff <= csr_wdata[ADC_W-1:0];
            REG_ENTRIES:    entries_ff    <= csr_wdata[ENT_W-1:0];
            default: ;
         endcase
      end
   end

   // effective entry count, clamped to at least MIN_ENTRIES and at most the table
   logic [N_W-1:0]   n_eff;
   logic [IDX_W-1:0] last_idx;

   always_comb begin
      if (entries_ff < ENT_W'(MIN_ENTRIES)) begin
         n_eff = N_W'(MIN_ENTRIES);
      end else if (N_W'(entries_ff) > N_W'(TABLE_ENTRIES)) begin
         n_eff = N_W'(TABLE_ENTRIES);
      end else begin
         n_eff = N_W'(entries_ff);
      end
   end

   assign last_idx = IDX_W'(n_eff - N_W'(2));

   // state
   state_type               state_ff, state_in;
   logic                    fault_ff, fault_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;
   logic [ADC_W-1:0]        sample_ff, sample_in;
   logic                    bad_ff, bad_in;
   logic [Q8_W-1:0]         q_ff, q_in;
   logic [IDX_W-1:0]        rd_idx_ff, rd_idx_in;
   logic [IDX_W-1:0]        dat_idx_ff, dat_idx_in;
   logic [ADC_W-1:0]        a0_ff, a0_in, a1_ff, a1_in;
   logic [CEL_W-1:0]        c0_ff, c0_in, c1_ff, c1_in;
   logic signed [ADC_W:0]   diff_ff, diff_in;
   logic signed [ADC_W:0]   sa_ff, sa_in;
   logic signed [CEL_W:0]   dc_ff, dc_in;
   logic signed [MUL_W-1:0] prod_ff, prod_in;
   logic signed [NUM_W-1:0] num_ff, num_in;
   logic                    neg_ff, neg_in;

   // table RAM: adc in the low bits, celsius above
   logic             ram_we;
   logic [IDX_W-1:0] ram_raddr;
   logic [RAM_W-1:0] ram_rdata;
   logic [ADC_W-1:0] r_adc;
   logic [CEL_W-1:0] r_cel;

   assign ram_raddr = (state_ff == ST_IDLE) ? '0 : rd_idx_ff;
   assign r_adc     = ram_rdata[ADC_W-1:0];
   assign r_cel     = ram_rdata[RAM_W-1:ADC_W];

   thi_ram #(
      .WIDTH (RAM_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (IDX_W'(req_index)),
      .wr_data ({req_cel, req_adc}),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // shared multiplier: c0 * d, then (s - a0) * (c1 - c0)
   logic signed [CEL_W:0]   mul_a;
   logic signed [ADC_W:0]   mul_b;
   logic signed [MUL_W-1:0] mul_p;

   assign mul_a = (state_ff == ST_MUL0) ? $signed({c0_ff[CEL_W-1], c0_ff}) : dc_ff;
   assign mul_b = (state_ff == ST_MUL0) ? diff_ff : sa_ff;
   assign mul_p = mul_a * mul_b;

   // divider
   div_req_type            div_req;
   div_rsp_type            div_rsp;
   logic [NUM_W-1:0]       num_mag;
   logic [ADC_W-1:0]       diff_mag;
   logic                   sample_bad_now;

   assign num_mag  = num_ff[NUM_W-1] ? NUM_W'(-num_ff) : NUM_W'(num_ff);
   assign diff_mag = diff_ff[ADC_W] ? ADC_W'(-diff_ff) : ADC_W'(diff_ff);
   assign sample_bad_now = (req_sample <= fault_low_ff) || (req_sample > fault_high_ff);

   thi_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_comb begin
      state_in     = state_ff;
      fault_in     = fault_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      sample_in    = sample_ff;
      bad_in       = bad_ff;
      q_in         = q_ff;
      rd_idx_in    = rd_idx_ff;
      dat_idx_in   = dat_idx_ff;
      a0_in        = a0_ff;
      a1_in        = a1_ff;
      c0_in        = c0_ff;
      c1_in        = c1_ff;
      diff_in      = diff_ff;
      sa_in        = sa_ff;
      dc_in        = dc_ff;
      prod_in      = prod_ff;
      num_in       = num_ff;
      neg_in       = neg_ff;
      ram_we       = 1'b0;
      div_req      = '0;

      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               q_in       = '0;
               bad_in     = 1'b0;
               sample_in  = req_sample;
               rd_idx_in  = IDX_W'(1);
               dat_idx_in = '0;
               state_in   = ST_OUT;
               case (req_tuser)
                  KIND_WRITE: begin
                     ram_we = (int'(req_index) < TABLE_ENTRIES);
                  end
                  KIND_CONVERT: begin
                     bad_in   = sample_bad_now;
                     fault_in = fault_ff | sample_bad_now;
                     state_in = ST_SCAN;
                  end
                  KIND_CLEAR: begin
                     fault_in = 1'b0;
                  end
                  default: ;
               endcase
            end
         end

         // read data belongs to dat_idx; the next address is already out
         ST_SCAN: begin
            dat_idx_in = rd_idx_ff;
            rd_idx_in  = rd_idx_ff + IDX_W'(1);
            if (dat_idx_ff == '0) begin
               a0_in = r_adc;
               c0_in = r_cel;
            end else if (r_adc > sample_ff) begin
               a1_in    = r_adc;
               c1_in    = r_cel;
               state_in = ST_DIFF;
            end else if (dat_idx_ff == last_idx) begin
               state_in = ST_LAST;
            end else begin
               a0_in = r_adc;
               c0_in = r_cel;
            end
         end

         // overflow entry n-1
         ST_LAST: begin
            q_in     = {r_cel, 8'h00};
            state_in = ST_OUT;
         end

         ST_DIFF: begin
            diff_in = $signed({1'b0, a1_ff}) - $signed({1'b0, a0_ff});
            sa_in   = $signed({1'b0, sample_ff}) - $signed({1'b0, a0_ff});
            dc_in   = $signed({c1_ff[CEL_W-1], c1_ff}) - $signed({c0_ff[CEL_W-1], c0_ff});
            if (a1_ff == a0_ff) begin
               q_in     = {c0_ff, 8'h00};
               state_in = ST_OUT;
            end else begin
               state_in = ST_MUL0;
            end
         end

         ST_MUL0: begin
            prod_in  = mul_p;
            state_in = ST_MUL1;
         end

         ST_MUL1: begin
            num_in   = NUM_W'(prod_ff) + NUM_W'(mul_p);
            state_in = ST_DIVS;
         end

         // magnitudes into the divider, sign applied afterwards (truncation to zero)
         ST_DIVS: begin
            div_req.start    = 1'b1;
            div_req.dividend = {num_mag, 8'h00};
            div_req.divisor  = diff_mag;
            neg_in           = num_ff[NUM_W-1] ^ diff_ff[ADC_W];
            state_in         = ST_DIVW;
         end

         ST_DIVW: begin
            if (div_rsp.done) begin
               if (neg_ff) begin
                  q_in = (div_rsp.quotient > DVD_W'(Q8_NEG_MAG)) ?
                         Q8_MIN : Q8_W'(-div_rsp.quotient);
               end else begin
                  q_in = (div_rsp.quotient > DVD_W'(Q8_POS_MAG)) ?
                         Q8_MAX : div_rsp.quotient[Q8_W-1:0];
               end
               state_in = ST_OUT;
            end
         end

         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {{(RSP_DATA_W-Q8_W-2){1'b0}}, fault_ff, bad_ff, q_ff};
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fault_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fault_ff     <= fault_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      sample_ff   <= sample_in;
      bad_ff      <= bad_in;
      q_ff        <= q_in;
      rd_idx_ff   <= rd_idx_in;
      dat_idx_ff  <= dat_idx_in;
      a0_ff       <= a0_in;
      a1_ff       <= a1_in;
      c0_ff       <= c0_in;
      c1_ff       <= c1_in;
      diff_ff     <= diff_in;
      sa_ff       <= sa_in;
      dc_ff       <= dc_in;
      prod_ff     <= prod_in;
      num_ff      <= num_in;
      neg_ff      <= neg_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // one beat in flight: nothing taken in the cycle after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while previous beat still in flight");

   // the walk never looks past the last searched entry
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (dat_idx_ff <= last_idx))
      else $error("table walk ran beyond the searched range");

   // a zero-width segment is settled before the divider
   a_no_zero_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVS) |-> (diff_ff != '0))
      else $error("divider started with a zero-width segment");

   // divider finishes only while the sequencer waits for it
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_DIVW))
      else $error("divider result arrived outside the wait state");

   // a non-convert beat never reports a bad sample
   a_bad_only_convert: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (req_tuser != KIND_CONVERT)) |=> !bad_ff)
      else $error("sample_bad set on a non-convert beat");

endmodule

@@ rtl/core/thi_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.

module thi_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/thi_div.sv @@
// Bit-serial restoring divider: unsigned dividend by a non-zero 10-bit divisor,
// one quotient bit per cycle. Depends on thi_pkg.

module thi_div (
   input  logic                 clock,
   input  logic                 reset,
   input  thi_pkg::div_req_type div_req,
   output thi_pkg::div_rsp_type div_rsp
);
   import thi_pkg::*;

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [ADC_W-1:0] rem_ff, rem_in;
   logic [ADC_W-1:0] dvs_ff, dvs_in;
   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [ADC_W:0]   trial;
   logic             take;

   assign trial = {rem_ff, quo_ff[DVD_W-1]};
   assign take  = (trial >= {1'b0, dvs_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DVD_W);
         rem_in  = '0;
         dvs_in  = div_req.divisor;
         quo_in  = div_req.dividend;
      end else if (busy_ff) begin
         // remainder stays below the divisor, so the top trial bit is clear on no-take
         rem_in = take ? ADC_W'(trial - {1'b0, dvs_ff}) : trial[ADC_W-1:0];
         quo_in = {quo_ff[DVD_W-2:0], take};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule
